### sv/kdchr_pkg.sv
// ----------------------------------------------------------------------------
// kdchr_pkg
// Shared types and codes for the debounced key bank with click/hold events.
// ----------------------------------------------------------------------------
package kdchr_pkg;

  localparam int PIN_W     = 8;
  localparam int IDX_W     = 4;
  localparam int TICK_W    = 10;
  localparam int CFG_T_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // item function codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_STATUS = 2'd1;
  localparam logic [1:0] FUNC_CHECK  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  // want_state codes
  localparam logic [1:0] CHK_IDLE  = 2'd0;
  localparam logic [1:0] CHK_CLICK = 2'd1;
  localparam logic [1:0] CHK_HOLD  = 2'd2;

  // key_status codes
  localparam logic [2:0] ST_IDLE        = 3'd0;
  localparam logic [2:0] ST_CLICK_EVT   = 3'd1;
  localparam logic [2:0] ST_CLICK_NOEVT = 3'd2;
  localparam logic [2:0] ST_HOLD_EVT    = 3'd3;
  localparam logic [2:0] ST_HOLD_NOEVT  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD            = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT          = 3'd4;

  typedef struct packed {
    logic [1:0]       func;
    logic [PIN_W-1:0] pin_levels;
    logic [IDX_W-1:0] key_index;
    logic [1:0]       want_state;
  } in_item_t;

  typedef struct packed {
    logic [2:0] key_status;
    logic       check_match;
    logic       index_error;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]  tick_period_ms;
    logic [CFG_T_W-1:0] debounce_ms;
    logic [CFG_T_W-1:0] hold_ms;
    logic [CFG_T_W-1:0] repeat_ms;
  } lane_cfg_t;

  typedef struct packed {
    logic tick;
    logic level;
    logic clear;
  } lane_cmd_t;

  typedef struct packed {
    logic click;
    logic hold;
    logic pending;
  } lane_stat_t;

endpackage

### sv/key_debounce_click_hold_repeat_core.sv
// ----------------------------------------------------------------------------
// key_debounce_click_hold_repeat_core
// Bank of debounced keys with click, hold and autorepeat events.
// ----------------------------------------------------------------------------
//   channel | dir | handshake         | payload
//   in_     | in  | in_valid/in_ready | in_item_t: func, pin_levels, key_index,
//           |     |                   |   want_state
//   out_    | out | out_valid/ready   | out_item_t: key_status, check_match,
//           |     |                   |   index_error
//   cfg_    | in  | cfg_valid/ready   | cfg_index (register), cfg_data
//
// One item per cycle. Each key's lane updates on a tick in the cycle the item
// is accepted; a query reads and clears its lane then, and the result is written to
// the output queue. A two-entry output queue (output register plus skid)
// lets an item enter while a result waits; in_ready drops only when both are full.
// Reset is synchronous: key state, pending events and the queue clear and the
// config registers return to their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module key_debounce_click_hold_repeat_core import kdchr_pkg::*; #(
  parameter int NUM_KEYS   = 8,
  parameter int TIME_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // item input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // configuration
  logic [PIN_W-1:0] mask_r;
  lane_cfg_t        cfg_r;

  // lanes and merge
  lane_cmd_t           cmd  [NUM_KEYS];
  lane_stat_t          stat [NUM_KEYS];
  out_item_t           result;
  logic                has_result;
  logic [NUM_KEYS-1:0] clear;
  logic [PIN_W-1:0]    level;
  logic                in_acc, push, pop;

  // output queue: main entry drives the port, skid catches overflow
  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r               <= 8'd255;
      cfg_r.tick_period_ms <= 10'd10;
      cfg_r.debounce_ms    <= 16'd50;
      cfg_r.hold_ms        <= 16'd1000;
      cfg_r.repeat_ms      <= 16'd200;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACTIVE_LOW_MASK: mask_r               <= cfg_data[PIN_W-1:0];
        REG_TICK_PERIOD:     cfg_r.tick_period_ms <= cfg_data[TICK_W-1:0];
        REG_DEBOUNCE:        cfg_r.debounce_ms    <= cfg_data[CFG_T_W-1:0];
        REG_HOLD:            cfg_r.hold_ms        <= cfg_data[CFG_T_W-1:0];
        REG_REPEAT:          cfg_r.repeat_ms      <= cfg_data[CFG_T_W-1:0];
        default: ;  // unused index
      endcase
    end
  end

  assign in_ready = !skid_v_r;
  assign in_acc   = in_valid && in_ready;
  // pins made active-high through the polarity mask
  assign level    = in_data.pin_levels ^ mask_r;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
    assign cmd[i].tick  = in_acc && (in_data.func == FUNC_TICK);
    assign cmd[i].level = level[i];
    assign cmd[i].clear = in_acc && clear[i];

    kdchr_lane #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .cfg  (cfg_r),
      .cmd  (cmd[i]),
      .stat (stat[i])
    );
  end

  kdchr_merge #(
    .NUM_KEYS(NUM_KEYS)
  ) u_merge (
    .item      (in_data),
    .stat      (stat),
    .result    (result),
    .has_result(has_result),
    .clear     (clear)
  );

  // result queue; a push never coincides with a full skid (in_ready low)
  assign push = in_acc && has_result;
  assign pop  = main_v_r && out_ready;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_nxt = result;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r) begin
        main_nxt   = result;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = result;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

### sv/kdchr_lane.sv
// ----------------------------------------------------------------------------
// kdchr_lane
// One key: debounce counter, clean level and idle/click/hold machine.
// ----------------------------------------------------------------------------
module kdchr_lane import kdchr_pkg::*; #(
  parameter int TIME_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lane_cfg_t  cfg,
  input  lane_cmd_t  cmd,
  output lane_stat_t stat
);

  localparam int SUM_W = ((TIME_WIDTH > TICK_W) ? TIME_WIDTH : TICK_W) + 1;
  localparam int CMP_W = (TIME_WIDTH > CFG_T_W) ? TIME_WIDTH : CFG_T_W;

  typedef enum logic [1:0] {
    M_IDLE  = 2'd0,
    M_CLICK = 2'd1,
    M_HOLD  = 2'd2
  } mode_t;

  mode_t                 mode_r, mode_nxt;
  logic                  prev_r, prev_nxt;
  logic                  clean_r, clean_nxt;
  logic                  pend_r, pend_nxt;
  logic [TIME_WIDTH-1:0] stable_r, stable_nxt;
  logic [TIME_WIDTH-1:0] mtime_r, mtime_nxt;

  logic [SUM_W-1:0]      st_sum, mt_sum;
  logic [TIME_WIDTH-1:0] st_sat, mt_sat, st_new;
  logic [CFG_T_W-1:0]    thr;
  logic                  clean_new, thr_hit;

  // saturating adds of the tick period
  assign st_sum = SUM_W'(stable_r) + SUM_W'(cfg.tick_period_ms);
  assign mt_sum = SUM_W'(mtime_r) + SUM_W'(cfg.tick_period_ms);
  assign st_sat = (|st_sum[SUM_W-1:TIME_WIDTH]) ? '1 : st_sum[TIME_WIDTH-1:0];
  assign mt_sat = (|mt_sum[SUM_W-1:TIME_WIDTH]) ? '1 : mt_sum[TIME_WIDTH-1:0];

  assign st_new    = (prev_r == cmd.level) ? st_sat : '0;
  assign clean_new = (CMP_W'(st_new) >= CMP_W'(cfg.debounce_ms)) ? cmd.level : clean_r;
  assign thr       = (mode_r == M_CLICK) ? cfg.hold_ms : cfg.repeat_ms;
  assign thr_hit   = CMP_W'(mt_sat) > CMP_W'(thr);

  always_comb begin
    mode_nxt   = mode_r;
    prev_nxt   = prev_r;
    clean_nxt  = clean_r;
    pend_nxt   = pend_r;
    stable_nxt = stable_r;
    mtime_nxt  = mtime_r;
    if (cmd.clear) begin
      pend_nxt = 1'b0;
    end
    if (cmd.tick) begin
      stable_nxt = st_new;
      prev_nxt   = cmd.level;
      clean_nxt  = clean_new;
      unique case (mode_r)
        M_CLICK, M_HOLD: begin
          if (!clean_new) begin
            mode_nxt = M_IDLE;
          end else if (thr_hit) begin
            mode_nxt  = M_HOLD;
            mtime_nxt = '0;
            pend_nxt  = 1'b1;
          end else begin
            mtime_nxt = mt_sat;
          end
        end
        default: begin
          if (clean_new) begin
            mode_nxt  = M_CLICK;
            mtime_nxt = '0;
            pend_nxt  = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      prev_r   <= 1'b0;
      clean_r  <= 1'b0;
      pend_r   <= 1'b0;
      stable_r <= '0;
      mtime_r  <= '0;
    end else begin
      mode_r   <= mode_nxt;
      prev_r   <= prev_nxt;
      clean_r  <= clean_nxt;
      pend_r   <= pend_nxt;
      stable_r <= stable_nxt;
      mtime_r  <= mtime_nxt;
    end
  end

  assign stat.click   = (mode_r == M_CLICK);
  assign stat.hold    = (mode_r == M_HOLD);
  assign stat.pending = pend_r;

endmodule

### sv/kdchr_merge.sv
// ----------------------------------------------------------------------------
// kdchr_merge
// Picks the addressed lane, forms the result and the per-lane event clears.
// ----------------------------------------------------------------------------
module kdchr_merge import kdchr_pkg::*; #(
  parameter int NUM_KEYS = 8
) (
  input  in_item_t            item,
  input  lane_stat_t          stat [NUM_KEYS],
  output out_item_t           result,
  output logic                has_result,
  output logic [NUM_KEYS-1:0] clear
);

  logic [NUM_KEYS-1:0] sel;
  logic                s_click, s_hold, s_pend, idx_ok;

  always_comb begin
    s_click = 1'b0;
    s_hold  = 1'b0;
    s_pend  = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      sel[i]  = (item.key_index == IDX_W'(i));
      s_click = s_click | (sel[i] & stat[i].click);
      s_hold  = s_hold  | (sel[i] & stat[i].hold);
      s_pend  = s_pend  | (sel[i] & stat[i].pending);
    end
    idx_ok = (item.key_index < IDX_W'(NUM_KEYS));
  end

  always_comb begin
    result     = '0;
    has_result = 1'b0;
    clear      = '0;
    unique case (item.func)
      FUNC_STATUS: begin
        has_result = 1'b1;
        if (!idx_ok) begin
          result.index_error = 1'b1;
        end else begin
          if (s_click) begin
            result.key_status = s_pend ? ST_CLICK_EVT : ST_CLICK_NOEVT;
          end else if (s_hold) begin
            result.key_status = s_pend ? ST_HOLD_EVT : ST_HOLD_NOEVT;
          end
          if (s_click || s_hold) begin
            clear = sel;
          end
        end
      end
      FUNC_CHECK: begin
        has_result = 1'b1;
        if (!idx_ok) begin
          result.index_error = 1'b1;
        end else begin
          case (item.want_state)
            CHK_IDLE: result.check_match = !s_click && !s_hold;
            CHK_CLICK: begin
              result.check_match = s_click && s_pend;
              if (s_click) clear = sel;
            end
            CHK_HOLD: begin
              result.check_match = s_hold && s_pend;
              if (s_hold) clear = sel;
            end
            default: result.check_match = 1'b0;
          endcase
        end
      end
      FUNC_CLEAR: clear = '1;
      default: ;
    endcase
  end

endmodule

### sv/kdchr_checker.sv
// ----------------------------------------------------------------------------
// kdchr_checker
// Port-level checks for the key bank, bound to the top level.
// ----------------------------------------------------------------------------
module kdchr_checker import kdchr_pkg::*; #(
  parameter int NUM_KEYS = 8
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic query_acc, quiet_acc;

  assign query_acc = in_valid && in_ready &&
                     (in_data.func == FUNC_STATUS || in_data.func == FUNC_CHECK);
  assign quiet_acc = in_valid && in_ready &&
                     (in_data.func == FUNC_TICK || in_data.func == FUNC_CLEAR);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a query into an empty queue shows up next cycle
  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc && !out_valid |=> out_valid)
    else $error("query result missing");

  // ticks and clears produce nothing
  a_quiet_item: assert property (@(posedge clk) disable iff (!rst_n)
    quiet_acc && !out_valid |=> !out_valid)
    else $error("result from tick or clear");

  // bad index reports error with zeroed fields
  a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc && !out_valid && (in_data.key_index >= IDX_W'(NUM_KEYS)) |=>
      out_data.index_error && out_data.key_status == ST_IDLE && !out_data.check_match)
    else $error("bad index result wrong");

  // status and match never both set
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.check_match && out_data.key_status != ST_IDLE))
    else $error("status and match both set");

endmodule

bind key_debounce_click_hold_repeat_core kdchr_checker #(
  .NUM_KEYS(NUM_KEYS)
) u_kdchr_checker (.*);
